[hw/rtl/snake_order_matrix_sort_assert.svh]
// Assertion macros used by the snake-order matrix sort top level.
`ifndef SNAKE_ORDER_MATRIX_SORT_ASSERT_SVH
`define SNAKE_ORDER_MATRIX_SORT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SOMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("snake_order_matrix_sort: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SOMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("snake_order_matrix_sort: next-cycle check failed");

`endif

[hw/rtl/soms_pkg.sv]
// Shared constants and controller/datapath interface types for the matrix sort.
package soms_pkg;

  localparam int VALUE_W     = 32;
  localparam int IDX_W       = 6;
  localparam int RC_W        = 3;
  localparam int SIDE_W      = 4;
  localparam int CNT_W       = 7;
  localparam int OUT_TDATA_W = 48;
  localparam int MAX_SIDE_DEF = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             insert;
    logic [CNT_W-1:0] cnt;
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [RC_W-1:0]  row;
    logic [RC_W-1:0]  col;
    logic             last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_ok;
  } status_t;

endpackage

[hw/rtl/snake_order_matrix_sort.sv]
// Top level of the snake-order matrix sort.
// The block takes an m by m matrix as m*m signed values in row-major order, one
// transaction per cycle while loading; each value is inserted into a sorted cell
// chain as it arrives, equal values keeping their arrival order. After the last
// value the chain drains into the grid memory in snake order, during which no
// input is taken, and the grid is then read out row-major at up to one
// transaction per cycle, each result passing through the memory read register
// and the output register; output back-pressure stretches the read-out.
// Loading of the next matrix starts as soon as the last grid read is issued.
// Writing the side register restarts any partial load; a side of zero counts as
// one and a side above MAX_SIDE saturates.
module snake_order_matrix_sort #(
  parameter int MAX_SIDE = soms_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Side register.
  input  logic                             cfg_wr_en,
  input  logic [soms_pkg::SIDE_W-1:0]      cfg_wr_data,
  // Input stream; tdata: value[31:0].
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [soms_pkg::VALUE_W-1:0]     in_tdata,
  // Result stream; tdata: value_out[31:0], source_index[37:32], row[40:38],
  // column[43:41], zero[47:44]; tlast marks the final cell.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [soms_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  soms_pkg::cmd_t    cmd;
  soms_pkg::status_t status;
  logic              in_accept;
  logic signed [soms_pkg::VALUE_W-1:0] out_value;
  logic [soms_pkg::IDX_W-1:0]          out_index;
  logic [soms_pkg::RC_W-1:0]           out_row, out_col;

  assign in_accept = in_tvalid && in_tready;

  soms_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_accept  (in_accept),
    .in_ready   (in_tready),
    .status     (status),
    .cmd        (cmd)
  );

  soms_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_value (signed'(in_tdata)),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_value(out_value),
    .out_index(out_index),
    .out_row  (out_row),
    .out_col  (out_col),
    .out_last (out_tlast)
  );

  // Pack the result fields, highest first, with zero padding in the top bits.
  assign out_tdata = {
    (soms_pkg::OUT_TDATA_W - soms_pkg::VALUE_W - soms_pkg::IDX_W - 2 * soms_pkg::RC_W)'(0),
    out_col, out_row, out_index, out_value
  };

`include "snake_order_matrix_sort_assert.svh"

  // Draining and grid reads never overlap, and no input is taken while draining.
  `SOMS_ASSERT_SAME(a_drain_no_read, clk, rst_n, cmd.wr_en, !cmd.rd_en)
  `SOMS_ASSERT_SAME(a_drain_no_input, clk, rst_n, cmd.shift, !in_tready)
  // A result that is not taken stays offered with unchanged contents.
  `SOMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

[hw/rtl/soms_ctrl.sv]
// Controller: load counting, drain sequencing and grid read sequencing.
module soms_ctrl #(
  parameter int MAX_SIDE = soms_pkg::MAX_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [soms_pkg::SIDE_W-1:0] cfg_wr_data,
  input  logic                        in_accept,
  output logic                        in_ready,
  input  soms_pkg::status_t           status,
  output soms_pkg::cmd_t              cmd
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [soms_pkg::SIDE_W-1:0]  side_r, side_nxt;
  logic [soms_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [soms_pkg::RC_W-1:0]    row_r, row_nxt;
  logic [soms_pkg::RC_W-1:0]    col_r, col_nxt;
  logic [soms_pkg::SIDE_W-1:0]  m;
  logic [soms_pkg::RC_W-1:0]    m_m1;
  logic [soms_pkg::CNT_W-1:0]   total_m1;
  logic                         grid_last;
  logic                         step;
  logic [soms_pkg::RC_W-1:0]    snake_col;

  // Side in use, clamped to 1..MAX_SIDE.
  always_comb begin
    if (side_r == '0) begin
      m = soms_pkg::SIDE_W'(1);
    end else if (side_r > soms_pkg::SIDE_W'(MAX_SIDE)) begin
      m = soms_pkg::SIDE_W'(MAX_SIDE);
    end else begin
      m = side_r;
    end
  end

  assign m_m1      = soms_pkg::RC_W'(m - soms_pkg::SIDE_W'(1));
  assign total_m1  = soms_pkg::CNT_W'(m) * soms_pkg::CNT_W'(m) - soms_pkg::CNT_W'(1);
  assign grid_last = (row_r == m_m1) && (col_r == m_m1);
  assign snake_col = row_r[0] ? (m_m1 - col_r) : col_r;
  assign in_ready  = (state_r == ST_LOAD);

  // Command decode.
  always_comb begin
    cmd         = '0;
    cmd.insert  = in_accept;
    cmd.cnt     = cnt_r;
    cmd.shift   = (state_r == ST_DRAIN);
    cmd.wr_en   = (state_r == ST_DRAIN);
    cmd.wr_addr = soms_pkg::IDX_W'(int'(row_r) * MAX_SIDE + int'(snake_col));
    cmd.rd_en   = (state_r == ST_EMIT) && status.rd_ok;
    cmd.rd_addr = soms_pkg::IDX_W'(int'(row_r) * MAX_SIDE + int'(col_r));
    cmd.row     = row_r;
    cmd.col     = col_r;
    cmd.last    = grid_last;
  end

  // Grid walk advances once per drained cell or issued read.
  assign step = cmd.shift || cmd.rd_en;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_accept) begin
          if (cnt_r == total_m1) begin
            cnt_nxt   = '0;
            row_nxt   = '0;
            col_nxt   = '0;
            state_nxt = ST_DRAIN;
          end else begin
            cnt_nxt = cnt_r + soms_pkg::CNT_W'(1);
          end
        end
      end
      ST_DRAIN, ST_EMIT: begin
        if (step) begin
          if (grid_last) begin
            row_nxt   = '0;
            col_nxt   = '0;
            state_nxt = (state_r == ST_DRAIN) ? ST_EMIT : ST_LOAD;
          end else if (col_r == m_m1) begin
            col_nxt = '0;
            row_nxt = row_r + soms_pkg::RC_W'(1);
          end else begin
            col_nxt = col_r + soms_pkg::RC_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
    // A side write restarts the load.
    if (cfg_wr_en) begin
      side_nxt = cfg_wr_data;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      side_r  <= soms_pkg::SIDE_W'(MAX_SIDE);
      cnt_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

[hw/rtl/soms_dp.sv]
// Datapath: insertion sorting chain, grid memory and two-stage output pipeline.
module soms_dp #(
  parameter int MAX_SIDE = soms_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  soms_pkg::cmd_t                   cmd,
  output soms_pkg::status_t                status,
  input  logic signed [soms_pkg::VALUE_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [soms_pkg::VALUE_W-1:0] out_value,
  output logic [soms_pkg::IDX_W-1:0]       out_index,
  output logic [soms_pkg::RC_W-1:0]        out_row,
  output logic [soms_pkg::RC_W-1:0]        out_col,
  output logic                             out_last
);

  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  // Sorting chain: cell 0 holds the smallest value loaded so far.
  logic signed [soms_pkg::VALUE_W-1:0] chain_val_r [CELLS];
  logic [soms_pkg::VALUE_W-1:0]        chain_val_nxt [CELLS];
  logic [ADDR_W-1:0]                   chain_idx_r [CELLS];
  logic [ADDR_W-1:0]                   chain_idx_nxt [CELLS];
  logic [CELLS-1:0]                    gt;

  // Grid memory, addressed row-major.
  logic [soms_pkg::VALUE_W-1:0] val_mem [CELLS];
  logic [ADDR_W-1:0]            idx_mem [CELLS];

  // Stage 1 is the memory read register; stage 2 is the output register.
  logic signed [soms_pkg::VALUE_W-1:0] s1_val_r;
  logic [ADDR_W-1:0]                   s1_idx_r;
  logic [soms_pkg::RC_W-1:0]           s1_row_r, s1_col_r;
  logic                                s1_last_r;
  logic                                s1_v_r, s1_v_nxt;
  logic signed [soms_pkg::VALUE_W-1:0] s2_val_r;
  logic [ADDR_W-1:0]                   s2_idx_r;
  logic [soms_pkg::RC_W-1:0]           s2_row_r, s2_col_r;
  logic                                s2_last_r;
  logic                                s2_v_r, s2_v_nxt;
  logic                                move;

  // A cell ranks after the new value if it is empty or strictly greater,
  // so equal values keep their arrival order.
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      gt[i] = (soms_pkg::CNT_W'(i) >= cmd.cnt) || (chain_val_r[i] > in_value);
    end
  end

  // Chain update: insert shifts the tail up, drain shifts everything down.
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      chain_val_nxt[i] = chain_val_r[i];
      chain_idx_nxt[i] = chain_idx_r[i];
      if (cmd.shift) begin
        if (i < CELLS - 1) begin
          chain_val_nxt[i] = chain_val_r[(i + 1) % CELLS];
          chain_idx_nxt[i] = chain_idx_r[(i + 1) % CELLS];
        end
      end else if (cmd.insert) begin
        if (i > 0 && gt[(i + CELLS - 1) % CELLS]) begin
          chain_val_nxt[i] = chain_val_r[(i + CELLS - 1) % CELLS];
          chain_idx_nxt[i] = chain_idx_r[(i + CELLS - 1) % CELLS];
        end else if (gt[i]) begin
          chain_val_nxt[i] = in_value;
          chain_idx_nxt[i] = ADDR_W'(cmd.cnt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CELLS; i++) begin
      chain_val_r[i] <= chain_val_nxt[i];
      chain_idx_r[i] <= chain_idx_nxt[i];
    end
  end

  // Memory write from the head of the chain, read into stage 1.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      val_mem[cmd.wr_addr[ADDR_W-1:0]] <= chain_val_r[0];
      idx_mem[cmd.wr_addr[ADDR_W-1:0]] <= chain_idx_r[0];
    end
    if (cmd.rd_en) begin
      s1_val_r  <= val_mem[cmd.rd_addr[ADDR_W-1:0]];
      s1_idx_r  <= idx_mem[cmd.rd_addr[ADDR_W-1:0]];
      s1_row_r  <= cmd.row;
      s1_col_r  <= cmd.col;
      s1_last_r <= cmd.last;
    end
  end

  // Pipeline flow control.
  assign move         = s1_v_r && (!s2_v_r || out_ready);
  assign status.rd_ok = !s1_v_r || move;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (cmd.rd_en) begin
      s1_v_nxt = 1'b1;
    end else if (move) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (move) begin
      s2_v_nxt = 1'b1;
    end else if (out_ready) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s2_val_r  <= s1_val_r;
      s2_idx_r  <= s1_idx_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_last_r <= s1_last_r;
    end
  end

  assign out_valid = s2_v_r;
  assign out_value = s2_val_r;
  assign out_index = soms_pkg::IDX_W'(s2_idx_r);
  assign out_row   = s2_row_r;
  assign out_col   = s2_col_r;
  assign out_last  = s2_last_r;

endmodule
